@@ sv/vaxcvt_pkg.sv @@
// ----------------------------------------------------------------------------
// vaxcvt_pkg: shared types and constants for the VAX / IEEE float converter
// Conversion mode codes, register map and exponent limits.
// ----------------------------------------------------------------------------
package vaxcvt_pkg;

  localparam int unsigned WORD_W     = 64;
  localparam int unsigned MODE_W     = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_IEEE64_TO_G = 3'd0,
    MODE_G_TO_IEEE64 = 3'd1,
    MODE_D_TO_IEEE64 = 3'd2,
    MODE_IEEE32_TO_F = 3'd3,
    MODE_F_TO_IEEE32 = 3'd4
  } conv_mode_t;

  // register byte addresses
  localparam logic [CFG_ADDR_W-1:0] REG_CONVERSION_MODE = 2'd0;

  localparam logic [15:0] G_EXP_MASK    = 16'h7ff0;
  localparam logic [15:0] G_EXP_OVF     = 16'h7fe0;
  localparam logic [15:0] G_EXP_STEP    = 16'h0020;
  localparam logic [15:0] G_EXP_MIN     = 16'h0030;
  localparam logic [31:0] D_EXP_MASK    = 32'h7f800000;
  localparam logic [31:0] D_EXP_MIN     = 32'h01800000;
  localparam logic [31:0] D_EXP_STEP    = 32'h01000000;
  localparam logic [31:0] D_REBIAS      = 32'h38000000;
  localparam logic [7:0]  F_EXP_MAX     = 8'hfd;
  localparam logic [7:0]  F_EXP_MIN     = 8'h03;
  localparam logic [63:0] G_SATURATE    = 64'hff7fffffffffffff;
  localparam logic [31:0] F_SATURATE    = 32'hff7fffff;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
  } conv_ctrl_t;

endpackage

@@ sv/vaxcvt_core.sv @@
// ----------------------------------------------------------------------------
// vaxcvt_core: conversion datapath
// Exponent adjust, range checks and byte swaps for one word, combinational.
// ----------------------------------------------------------------------------
module vaxcvt_core (
  input  vaxcvt_pkg::conv_ctrl_t           ctrl,
  input  logic [vaxcvt_pkg::WORD_W-1:0]    src_word,
  output logic [vaxcvt_pkg::WORD_W-1:0]    dst_word
);

  logic [7:0]  b [8];
  logic [15:0] g_s;
  logic [15:0] g_s_adj;
  logic [15:0] gi_s;
  logic [15:0] gi_s_adj;
  logic [31:0] d_hi;
  logic [31:0] d_hi_sub;
  logic [31:0] d_hi_shr;
  logic [31:0] d_hi_out;
  logic [31:0] d_lo_raw;
  logic [31:0] d_lo_out;
  logic [7:0]  f_e;
  logic [7:0]  f_b0_inc;
  logic [7:0]  fi_e;
  logic [7:0]  fi_b1_dec;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      b[i] = src_word[63-8*i -: 8];
    end
  end

  always_comb begin
    g_s      = {b[0], b[1]};
    g_s_adj  = g_s + vaxcvt_pkg::G_EXP_STEP;
    gi_s     = {b[1], b[0]};
    gi_s_adj = gi_s - vaxcvt_pkg::G_EXP_STEP;

    // D: drop bias step, shift the mantissa down three, then rebias
    d_hi     = {b[1], b[0], b[3], b[2]};
    d_hi_sub = d_hi - vaxcvt_pkg::D_EXP_STEP;
    d_hi_shr = {d_hi_sub[31], 3'b000, d_hi_sub[30:3]};
    d_hi_out = d_hi_shr + vaxcvt_pkg::D_REBIAS;
    d_lo_raw = {b[5], b[4], b[7], b[6]};
    d_lo_out = {b[2][2:0], d_lo_raw[31:3]};

    f_e       = {b[4][6:0], b[5][7]};
    f_b0_inc  = b[4] + 8'd1;
    fi_e      = {b[5][6:0], b[4][7]};
    fi_b1_dec = b[5] - 8'd1;

    unique case (ctrl.mode)
      vaxcvt_pkg::MODE_IEEE64_TO_G: begin
        if ((g_s & vaxcvt_pkg::G_EXP_MASK) >= vaxcvt_pkg::G_EXP_OVF) begin
          dst_word = vaxcvt_pkg::G_SATURATE;
        end else begin
          dst_word = {g_s_adj[7:0], g_s_adj[15:8], b[3], b[2], b[5], b[4], b[7], b[6]};
        end
      end
      vaxcvt_pkg::MODE_G_TO_IEEE64: begin
        if ((gi_s & vaxcvt_pkg::G_EXP_MASK) < vaxcvt_pkg::G_EXP_MIN) begin
          dst_word = '0;
        end else begin
          dst_word = {gi_s_adj, b[3], b[2], b[5], b[4], b[7], b[6]};
        end
      end
      vaxcvt_pkg::MODE_D_TO_IEEE64: begin
        if ((d_hi & vaxcvt_pkg::D_EXP_MASK) < vaxcvt_pkg::D_EXP_MIN) begin
          dst_word = '0;
        end else begin
          dst_word = {d_hi_out, d_lo_out};
        end
      end
      vaxcvt_pkg::MODE_IEEE32_TO_F: begin
        if (f_e == 8'd0) begin
          dst_word = '0;
        end else if (f_e > vaxcvt_pkg::F_EXP_MAX) begin
          dst_word = {32'd0, vaxcvt_pkg::F_SATURATE};
        end else begin
          dst_word = {32'd0, b[5], f_b0_inc, b[7], b[6]};
        end
      end
      vaxcvt_pkg::MODE_F_TO_IEEE32: begin
        if (fi_e < vaxcvt_pkg::F_EXP_MIN) begin
          dst_word = '0;
        end else begin
          dst_word = {32'd0, fi_b1_dec, b[4], b[7], b[6]};
        end
      end
      default: begin
        // unused modes pass the word through
        dst_word = src_word;
      end
    endcase
  end

endmodule

@@ sv/vax_ieee_float_converter_top.sv @@
// ----------------------------------------------------------------------------
// vax_ieee_float_converter_top: VAX / IEEE float word converter
// Converts one float word per beat between IEEE big-endian and VAX layouts.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid / in_stall carries in_source_word and in_last_in;
//   result channel out_valid / out_stall carries out_converted_word and
//   out_last_out. A beat moves at a clock edge with valid high, stall low.
//   The APB port holds one register, conversion_mode, at byte address 0;
//   write it only while no word is in flight. pready is tied high.
//   From input beat to result beat the word is held in an input register,
//   converted by the datapath and caught in the result register. One word
//   is taken every cycle while results drain.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more word; only then is in_stall raised.
//   Synchronous reset clears both valid flags and sets the mode to
//   IEEE double to VAX G.
// ----------------------------------------------------------------------------
module vax_ieee_float_converter_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [vaxcvt_pkg::WORD_W-1:0]       in_source_word,
  input  logic                                in_last_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [vaxcvt_pkg::WORD_W-1:0]       out_converted_word,
  output logic                                out_last_out,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [vaxcvt_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [vaxcvt_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [vaxcvt_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                                pready
);

  logic [vaxcvt_pkg::MODE_W-1:0] mode_r;
  logic                          s1_valid_r;
  logic [vaxcvt_pkg::WORD_W-1:0] s1_word_r;
  logic                          s1_last_r;
  logic                          out_valid_r;
  logic [vaxcvt_pkg::WORD_W-1:0] out_word_r;
  logic                          out_last_r;
  logic [vaxcvt_pkg::WORD_W-1:0] conv_word;
  logic                          advance;
  logic                          in_accept;
  logic                          cfg_write;
  vaxcvt_pkg::conv_ctrl_t        ctrl;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr == vaxcvt_pkg::REG_CONVERSION_MODE) ?
                     {{(vaxcvt_pkg::CFG_DATA_W-vaxcvt_pkg::MODE_W){1'b0}}, mode_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= vaxcvt_pkg::MODE_IEEE64_TO_G;
    end else if (cfg_write && paddr == vaxcvt_pkg::REG_CONVERSION_MODE) begin
      mode_r <= pwdata[vaxcvt_pkg::MODE_W-1:0];
    end
  end

  // move the held word on when the result register is free or draining
  assign advance   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  assign ctrl.mode = mode_r;

  vaxcvt_core u_core (
    .ctrl     (ctrl),
    .src_word (s1_word_r),
    .dst_word (conv_word)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_word_r <= in_source_word;
      s1_last_r <= in_last_in;
    end
    if (advance) begin
      out_word_r <= conv_word;
      out_last_r <= s1_last_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_converted_word = out_word_r;
  assign out_last_out       = out_last_r;

  a_stall_needs_held_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("in_stall raised with empty input register");

  a_accept_fills_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> s1_valid_r)
    else $error("accepted word not held");

  a_blocked_word_kept: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && out_stall |=> s1_valid_r && out_valid_r)
    else $error("word lost while result stalled");

  a_result_drains: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_stall && !s1_valid_r |=> !out_valid_r)
    else $error("result repeated after its beat");

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the VAX / IEEE float word converter
// Runs every conversion mode and unused codes 5 and 7 (pass-through). Boundary
// words open each first phase but code 5's; random words are biased towards the
// exponent limits in conversion modes. Converted words and last flags are checked
// against a predictor. The sender idles in bursts and the receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned CYCLE_LIMIT    = 200000;
  localparam int unsigned RANDOM_WORDS   = 40;
  localparam int unsigned PASS_WORDS     = 6;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned REPORT_LIMIT   = 100;
  localparam logic [vaxcvt_pkg::MODE_W-1:0] MODE_PASS_LO = 3'd5;
  localparam logic [vaxcvt_pkg::MODE_W-1:0] MODE_PASS_HI = 3'd7;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_style_t;

  typedef struct packed {
    logic [vaxcvt_pkg::WORD_W-1:0] bits;
    logic                          last_flag;
  } float_beat_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic [vaxcvt_pkg::WORD_W-1:0]     in_source_word = '0;
  logic                              in_last_in = 1'b0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic [vaxcvt_pkg::WORD_W-1:0]     out_converted_word;
  logic                              out_last_out;
  logic                              psel = 1'b0;
  logic                              penable = 1'b0;
  logic                              pwrite = 1'b0;
  logic [vaxcvt_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [vaxcvt_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [vaxcvt_pkg::CFG_DATA_W-1:0] prdata;
  logic                              pready;

  float_beat_t                   pending_words[$];
  float_beat_t                   expected_words[$];
  float_beat_t                   next_beat;
  float_beat_t                   want_beat;
  logic [vaxcvt_pkg::MODE_W-1:0] active_mode = vaxcvt_pkg::MODE_IEEE64_TO_G;
  int unsigned                   mismatch_count = 0;
  int unsigned                   cycle_count = 0;
  int unsigned                   phase_count = 0;
  int unsigned                   burst_left = 0;
  int unsigned                   gap_left = 0;
  int unsigned                   stall_span = 0;
  stall_style_t                  stall_style = STALL_NONE;

  vax_ieee_float_converter_top DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_source_word     (in_source_word),
    .in_last_in         (in_last_in),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_converted_word (out_converted_word),
    .out_last_out       (out_last_out),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always #6 clk = ~clk;

  // Expected bytes of one converted word in the given mode
  function automatic logic [vaxcvt_pkg::WORD_W-1:0] convert_word(
    input logic [vaxcvt_pkg::MODE_W-1:0] mode,
    input logic [vaxcvt_pkg::WORD_W-1:0] w);
    logic [15:0] s;
    logic [31:0] hi;
    logic [31:0] lo;
    logic [7:0]  e;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [47:0] tail;
    tail = {w[39:32], w[47:40], w[23:16], w[31:24], w[7:0], w[15:8]};
    b0 = w[31:24];
    b1 = w[23:16];
    convert_word = w;
    case (mode)
      vaxcvt_pkg::MODE_IEEE64_TO_G: begin
        s = w[63:48];
        if ((s & vaxcvt_pkg::G_EXP_MASK) >= vaxcvt_pkg::G_EXP_OVF) begin
          convert_word = vaxcvt_pkg::G_SATURATE;
        end else begin
          s = s + vaxcvt_pkg::G_EXP_STEP;
          convert_word = {s[7:0], s[15:8], tail};
        end
      end
      vaxcvt_pkg::MODE_G_TO_IEEE64: begin
        s = {w[55:48], w[63:56]};
        if ((s & vaxcvt_pkg::G_EXP_MASK) < vaxcvt_pkg::G_EXP_MIN) begin
          convert_word = '0;
        end else begin
          s = s - vaxcvt_pkg::G_EXP_STEP;
          convert_word = {s, tail};
        end
      end
      vaxcvt_pkg::MODE_D_TO_IEEE64: begin
        hi = {w[55:48], w[63:56], w[39:32], w[47:40]};
        if ((hi & vaxcvt_pkg::D_EXP_MASK) < vaxcvt_pkg::D_EXP_MIN) begin
          convert_word = '0;
        end else begin
          // widen the exponent to IEEE double width, keeping the sign in place
          hi = hi - vaxcvt_pkg::D_EXP_STEP;
          hi = {hi[31], 3'b000, hi[30:3]};
          hi = hi + vaxcvt_pkg::D_REBIAS;
          lo = {w[23:16], w[31:24], w[7:0], w[15:8]} >> 3;
          lo[31:29] = w[42:40];
          convert_word = {hi, lo};
        end
      end
      vaxcvt_pkg::MODE_IEEE32_TO_F: begin
        e = {b0[6:0], b1[7]};
        if (e == 8'h00) begin
          convert_word = '0;
        end else if (e > vaxcvt_pkg::F_EXP_MAX) begin
          convert_word = {32'h0, vaxcvt_pkg::F_SATURATE};
        end else begin
          b0 = b0 + 8'd1;
          convert_word = {32'h0, b1, b0, w[7:0], w[15:8]};
        end
      end
      vaxcvt_pkg::MODE_F_TO_IEEE32: begin
        e = {b1[6:0], b0[7]};
        if (e < vaxcvt_pkg::F_EXP_MIN) begin
          convert_word = '0;
        end else begin
          b1 = b1 - 8'd1;
          convert_word = {32'h0, b1, b0, w[7:0], w[15:8]};
        end
      end
      default: convert_word = w;
    endcase
  endfunction

  // Random word; a third of them get an exponent at the edge of the mode's range
  function automatic logic [vaxcvt_pkg::WORD_W-1:0] random_word(
    input logic [vaxcvt_pkg::MODE_W-1:0] mode);
    logic [vaxcvt_pkg::WORD_W-1:0] w;
    logic [10:0]                   e11;
    logic [7:0]                    e8;
    w = {$urandom, $urandom};
    e11 = ($urandom_range(0, 1) == 0) ? 11'($urandom_range(0, 3))
                                      : 11'h7ff - 11'($urandom_range(0, 3));
    e8 = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3))
                                     : 8'hff - 8'($urandom_range(0, 3));
    if ($urandom_range(0, 2) == 0) begin
      case (mode)
        vaxcvt_pkg::MODE_IEEE64_TO_G: w[62:52] = e11;
        vaxcvt_pkg::MODE_G_TO_IEEE64: {w[54:48], w[63:60]} = e11;
        vaxcvt_pkg::MODE_D_TO_IEEE64: {w[54:48], w[63]} = e8;
        vaxcvt_pkg::MODE_IEEE32_TO_F: w[30:23] = e8;
        vaxcvt_pkg::MODE_F_TO_IEEE32: {w[22:16], w[31]} = e8;
        default: ;
      endcase
    end
    random_word = w;
  endfunction

  task automatic report_mismatch(input string what,
                                 input logic [vaxcvt_pkg::WORD_W-1:0] got,
                                 input logic [vaxcvt_pkg::WORD_W-1:0] want);
    if (mismatch_count < REPORT_LIMIT)
      $display("mismatch: %s got %h want %h (mode %0d)", what, got, want, active_mode);
    mismatch_count++;
  endtask

  task automatic queue_word(input logic [vaxcvt_pkg::WORD_W-1:0] w);
    pending_words.push_back('{bits: w, last_flag: 1'($urandom_range(0, 1))});
  endtask

  // Hold until nothing is queued, on the wire or awaiting its result
  task automatic wait_idle();
    @(negedge clk);
    while (pending_words.size() != 0 || in_valid || expected_words.size() != 0)
      @(negedge clk);
  endtask

  task automatic program_mode(input logic [vaxcvt_pkg::MODE_W-1:0] mode);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= vaxcvt_pkg::REG_CONVERSION_MODE;
    pwdata  <= vaxcvt_pkg::CFG_DATA_W'(mode);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    active_mode = mode;
    // read back straight after the write
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== vaxcvt_pkg::CFG_DATA_W'(mode))
      report_mismatch("conversion_mode readback", vaxcvt_pkg::WORD_W'(prdata),
                      vaxcvt_pkg::WORD_W'(mode));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_phase(input logic [vaxcvt_pkg::MODE_W-1:0] mode,
                           input bit with_directed);
    int unsigned n;
    wait_idle();
    // the first phase runs on the mode left by reset
    if (phase_count != 0) program_mode(mode);
    phase_count++;
    @(negedge clk);
    if (with_directed) begin
      case (mode)
        vaxcvt_pkg::MODE_IEEE64_TO_G: begin
          queue_word(64'h0000_0000_0000_0000);
          queue_word(64'h7fe0_0000_0000_0000);
          queue_word(64'hffff_ffff_ffff_ffff);
          queue_word(64'h7fdf_ffff_ffff_ffff);
          queue_word(64'h3ff0_0123_4567_89ab);
        end
        vaxcvt_pkg::MODE_G_TO_IEEE64: begin
          queue_word(64'h2f80_ffff_ffff_ffff);
          queue_word(64'h3000_0000_0000_0000);
          queue_word(64'hffff_ffff_ffff_ffff);
          queue_word(64'h4080_1122_3344_5566);
        end
        vaxcvt_pkg::MODE_D_TO_IEEE64: begin
          queue_word(64'h7f81_ffff_ffff_ffff);
          queue_word(64'h8001_0000_0000_0000);
          queue_word(64'hffff_ffff_ffff_ffff);
          queue_word(64'h8040_a5c3_1e2d_7f96);
        end
        vaxcvt_pkg::MODE_IEEE32_TO_F: begin
          queue_word(64'h0000_0000_807f_ffff);
          queue_word(64'h0000_0000_7eff_ffff);
          queue_word(64'h0000_0000_7f00_0000);
          queue_word(64'hffff_ffff_ffff_ffff);
          queue_word(64'hdead_beef_3f80_0000);
        end
        vaxcvt_pkg::MODE_F_TO_IEEE32: begin
          queue_word(64'h0000_0000_7f01_ffff);
          queue_word(64'h0000_0000_8001_0000);
          queue_word(64'hffff_ffff_ffff_ffff);
          queue_word(64'h1234_5678_0040_beef);
        end
        default: begin
          queue_word(64'hffff_ffff_ffff_ffff);
          queue_word(64'h0000_0000_0000_0000);
        end
      endcase
    end
    n = (mode > vaxcvt_pkg::MODE_F_TO_IEEE32) ? PASS_WORDS : RANDOM_WORDS;
    repeat (n) queue_word(random_word(mode));
  endtask

  // Sender: bursts of beats separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid)
        expected_words.push_back('{bits: convert_word(active_mode, in_source_word),
                                   last_flag: in_last_in});
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_words.size() != 0) begin
        next_beat = pending_words.pop_front();
        in_valid       <= 1'b1;
        in_source_word <= next_beat.bits;
        in_last_in     <= next_beat.last_flag;
        if (burst_left != 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 23);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: check each result beat, then pick the next stall value
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        report_mismatch("result with nothing expected", out_converted_word, '0);
      end else begin
        want_beat = expected_words.pop_front();
        if (out_converted_word !== want_beat.bits)
          report_mismatch("converted_word", out_converted_word, want_beat.bits);
        if (out_last_out !== want_beat.last_flag)
          report_mismatch("last_out", vaxcvt_pkg::WORD_W'(out_last_out),
                          vaxcvt_pkg::WORD_W'(want_beat.last_flag));
      end
    end
    if (stall_span == 0) begin
      stall_style = stall_style_t'($urandom_range(0, 3));
      stall_span = $urandom_range(8, 64);
    end else begin
      stall_span--;
    end
    case (stall_style)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= stall_span[1];
    endcase
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    run_phase(vaxcvt_pkg::MODE_IEEE64_TO_G, 1'b1);
    run_phase(vaxcvt_pkg::MODE_G_TO_IEEE64, 1'b1);
    run_phase(vaxcvt_pkg::MODE_D_TO_IEEE64, 1'b1);
    run_phase(vaxcvt_pkg::MODE_IEEE32_TO_F, 1'b1);
    run_phase(vaxcvt_pkg::MODE_F_TO_IEEE32, 1'b1);
    run_phase(MODE_PASS_HI, 1'b1);
    run_phase(vaxcvt_pkg::MODE_F_TO_IEEE32, 1'b0);
    run_phase(vaxcvt_pkg::MODE_IEEE32_TO_F, 1'b0);
    run_phase(vaxcvt_pkg::MODE_D_TO_IEEE64, 1'b0);
    run_phase(vaxcvt_pkg::MODE_G_TO_IEEE64, 1'b0);
    run_phase(MODE_PASS_LO, 1'b0);
    run_phase(vaxcvt_pkg::MODE_IEEE64_TO_G, 1'b0);
    wait_idle();
    // let any stray result beat show up before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
